>>> rtl/bssp_pkg.sv
// Shared field widths and operation and result codes for the shortest-path relaxation block.
package bssp_pkg;

  localparam int unsigned OpW      = 3;
  localparam int unsigned VtxW     = 16;
  localparam int unsigned ValW     = 32;
  localparam int unsigned WgtW     = 16;
  localparam int unsigned KindW    = 2;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  typedef logic [OpW-1:0]   op_t;
  typedef logic [KindW-1:0] kind_t;

  localparam op_t OpInit    = 3'd0;
  localparam op_t OpMessage = 3'd1;
  localparam op_t OpEval    = 3'd2;
  localparam op_t OpEdge    = 3'd3;
  localparam op_t OpStepEnd = 3'd4;

  localparam kind_t KindNone    = 2'd0;
  localparam kind_t KindMessage = 2'd1;
  localparam kind_t KindTarget  = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgSource = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgTarget = 1'd1;

endpackage

>>> rtl/bssp_if.sv
// Handshake channel interfaces for input items, result items and configuration writes.
interface bssp_in_if
  import bssp_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [OpW-1:0]  op;
  logic [VtxW-1:0] vertex;
  logic [ValW-1:0] value;
  logic [WgtW-1:0] weight;

  modport source (output valid, op, vertex, value, weight, input ready);
  modport sink   (input valid, op, vertex, value, weight, output ready);
endinterface

interface bssp_out_if
  import bssp_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [KindW-1:0] kind;
  logic [VtxW-1:0]  dest;
  logic [ValW-1:0]  dist_res;
  logic             updated;

  modport source (output valid, kind, dest, dist_res, updated, input ready);
  modport sink   (input valid, kind, dest, dist_res, updated, output ready);
endinterface

interface bssp_cfg_if
  import bssp_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/bssp_ram.sv
// Generic single-port synchronous RAM with registered read data.
module bssp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/bounded_sssp_vertex_relaxation.sv
// Top level of the bounded shortest-path vertex relaxation engine.
// A result is registered as its item is accepted, except for an evaluate of an in-range
// vertex: that reads the table first, then compares and writes back in the eval state.
// One item per cycle while the output is not stalled; an in-range evaluate holds off the
// next item until its eval state ends. A result waiting on the output does not block the
// next item while the output is taken in the same cycle.
// Reset clears all control registers and bounds; the distance table is not cleared.
module bounded_sssp_vertex_relaxation
  import bssp_pkg::*;
#(
  parameter int unsigned VERTEX_COUNT = 65536,
  parameter int unsigned DIST_BITS    = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bssp_in_if.sink    in_i,
  bssp_out_if.source out_o,
  bssp_cfg_if.sink   cfg_i
);

  localparam int unsigned AW = $clog2(VERTEX_COUNT);
  localparam int unsigned DW = DIST_BITS;
  localparam int unsigned SW = ((DW > WgtW) ? DW : WgtW) + 1;

  localparam logic StIdle = 1'b0;
  localparam logic StEval = 1'b1;

  localparam logic [DW-1:0] DistOnes = '1;

  logic state_q, state_d;

  logic [VtxW-1:0] source_q, target_q;
  logic [DW-1:0]   msg_min_q, msg_min_d;
  logic [DW-1:0]   cur_dist_q, cur_dist_d;
  logic            active_q, active_d;
  logic            first_q, first_d;
  logic [DW-1:0]   bound_now_q, bound_now_d;
  logic [DW-1:0]   bound_next_q, bound_next_d;

  logic [VtxW-1:0] eval_vtx_q, eval_vtx_d;

  logic             out_valid_q, out_valid_d;
  logic [KindW-1:0] out_kind_q, out_kind_d;
  logic [VtxW-1:0]  out_dest_q, out_dest_d;
  logic [ValW-1:0]  out_dist_q, out_dist_d;
  logic             out_upd_q, out_upd_d;
  logic             out_load;

  logic            accept;
  logic            in_range;
  logic [DW-1:0]   in_value;
  logic [SW-1:0]   edge_sum;
  logic [DW-1:0]   edge_dist;

  logic            ram_en, ram_we;
  logic [AW-1:0]   ram_addr;
  logic [DW-1:0]   ram_wdata, ram_rdata;

  logic [DW-1:0]   stored;
  logic [DW-1:0]   cur;
  logic            take;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      source_q <= '0;
      target_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CfgSource: source_q <= cfg_i.data;
        CfgTarget: target_q <= cfg_i.data;
        default:   ;
      endcase
    end
  end

  assign in_i.ready = (state_q == StIdle) && (!out_valid_q || out_o.ready);
  assign accept     = in_i.valid && in_i.ready;
  assign in_range   = 32'(in_i.vertex) < 32'(VERTEX_COUNT);
  assign in_value   = DW'(in_i.value);

  // Saturating edge sum; the extra top bit catches overflow past the distance width.
  assign edge_sum  = SW'(cur_dist_q) + SW'(in_i.weight);
  assign edge_dist = (edge_sum > SW'(DistOnes)) ? DistOnes : edge_sum[DW-1:0];

  assign stored = ram_rdata;
  assign cur    = (stored < msg_min_q) ? stored : msg_min_q;
  assign take   = ((cur == '0) && first_q) || ((cur < stored) && (cur < bound_now_q));

  always_comb begin
    state_d      = state_q;
    msg_min_d    = msg_min_q;
    cur_dist_d   = cur_dist_q;
    active_d     = active_q;
    first_d      = first_q;
    bound_now_d  = bound_now_q;
    bound_next_d = bound_next_q;
    eval_vtx_d   = eval_vtx_q;
    out_load     = 1'b0;
    out_kind_d   = KindNone;
    out_dest_d   = '0;
    out_dist_d   = '0;
    out_upd_d    = 1'b0;
    ram_en       = 1'b0;
    ram_we       = 1'b0;
    ram_addr     = AW'(in_i.vertex);
    ram_wdata    = (in_i.vertex == source_q) ? '0 : DistOnes;

    if (state_q == StEval) begin
      ram_addr   = AW'(eval_vtx_q);
      ram_wdata  = cur;
      out_load   = 1'b1;
      out_dest_d = eval_vtx_q;
      out_dist_d = ValW'(cur);
      msg_min_d  = DistOnes;
      state_d    = StIdle;
      if (take) begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        out_upd_d = 1'b1;
        if (eval_vtx_q == target_q) begin
          out_kind_d   = KindTarget;
          bound_next_d = (cur < bound_next_q) ? cur : bound_next_q;
        end else begin
          active_d   = 1'b1;
          cur_dist_d = cur;
        end
      end
    end else if (accept) begin
      unique case (in_i.op)
        OpInit: begin
          out_load = 1'b1;
          ram_en   = in_range;
          ram_we   = 1'b1;
        end
        OpMessage: begin
          out_load  = 1'b1;
          msg_min_d = (in_value < msg_min_q) ? in_value : msg_min_q;
        end
        OpEval: begin
          active_d = 1'b0;
          if (in_range) begin
            // Read the stored distance now; compare and write back next cycle.
            ram_en     = 1'b1;
            eval_vtx_d = in_i.vertex;
            state_d    = StEval;
          end else begin
            out_load  = 1'b1;
            msg_min_d = DistOnes;
          end
        end
        OpEdge: begin
          out_load = 1'b1;
          if (active_q && (edge_dist < bound_now_q)) begin
            out_kind_d = KindMessage;
            out_dest_d = in_i.vertex;
            out_dist_d = ValW'(edge_dist);
          end
        end
        OpStepEnd: begin
          out_load    = 1'b1;
          bound_now_d = (bound_next_q < bound_now_q) ? bound_next_q : bound_now_q;
          first_d     = 1'b0;
          active_d    = 1'b0;
          msg_min_d   = DistOnes;
        end
        default: begin
          out_load = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      msg_min_q    <= DistOnes;
      cur_dist_q   <= DistOnes;
      active_q     <= 1'b0;
      first_q      <= 1'b1;
      bound_now_q  <= DistOnes;
      bound_next_q <= DistOnes;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      msg_min_q    <= msg_min_d;
      cur_dist_q   <= cur_dist_d;
      active_q     <= active_d;
      first_q      <= first_d;
      bound_now_q  <= bound_now_d;
      bound_next_q <= bound_next_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    eval_vtx_q <= eval_vtx_d;
    if (out_load) begin
      out_kind_q <= out_kind_d;
      out_dest_q <= out_dest_d;
      out_dist_q <= out_dist_d;
      out_upd_q  <= out_upd_d;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.kind     = out_kind_q;
  assign out_o.dest     = out_dest_q;
  assign out_o.dist_res = out_dist_q;
  assign out_o.updated  = out_upd_q;

  bssp_ram #(
    .WIDTH (DW),
    .DEPTH (VERTEX_COUNT)
  ) u_dist_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

endmodule

>>> tb/sv/bounded_sssp_vertex_relaxation_tb.sv
// Self-checking testbench for the bounded shortest-path vertex relaxation block.
`timescale 1ns / 1ps

module bounded_sssp_vertex_relaxation_tb
  import bssp_pkg::*;
();

  localparam int unsigned CycleLimit = 400000;
  localparam logic [ValW-1:0] DistOnes = '1;

  typedef struct packed {
    kind_t           kind;
    logic [VtxW-1:0] dest;
    logic [ValW-1:0] dist_res;
    logic            upd;
  } relax_res_t;

  // Tracks the engine state and keeps the results that accepted items must produce.
  class relax_scoreboard;
    logic [ValW-1:0] dist_tab [bit [VtxW-1:0]];
    logic [ValW-1:0] msg_min, cur_dist, bound_now, bound_next;
    bit              edges_on, first_step;
    bit [VtxW-1:0]   src_v, tgt_v;
    relax_res_t      expected_relax[$];
    int              n_fail, n_checked, n_msg, n_target, n_upd;

    function new();
      msg_min    = DistOnes;
      cur_dist   = DistOnes;
      bound_now  = DistOnes;
      bound_next = DistOnes;
      edges_on   = 1'b0;
      first_step = 1'b1;
      src_v      = '0;
      tgt_v      = '0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      if (idx == CfgSource) src_v = data;
      else if (idx == CfgTarget) tgt_v = data;
    endfunction

    function void note_item(op_t op, logic [VtxW-1:0] v, logic [ValW-1:0] value,
                            logic [WgtW-1:0] weight);
      relax_res_t      res;
      logic [ValW-1:0] stored, cur, sat;
      logic [ValW:0]   sum;
      res = '0;
      case (op)
        OpInit: dist_tab[v] = (v == src_v) ? '0 : DistOnes;
        OpMessage: if (value < msg_min) msg_min = value;
        OpEval: begin
          edges_on = 1'b0;
          stored = dist_tab.exists(v) ? dist_tab[v] : '0;
          cur = (stored < msg_min) ? stored : msg_min;
          res.dest = v;
          res.dist_res = cur;
          // A zero distance is taken unconditionally only in the first superstep.
          if ((cur == '0 && first_step) || (cur < stored && cur < bound_now)) begin
            dist_tab[v] = cur;
            res.upd = 1'b1;
            if (v == tgt_v) begin
              if (cur < bound_next) bound_next = cur;
              res.kind = KindTarget;
            end else begin
              edges_on = 1'b1;
              cur_dist = cur;
            end
          end
          msg_min = DistOnes;
        end
        OpEdge: if (edges_on) begin
          sum = (ValW+1)'(cur_dist) + (ValW+1)'(weight);
          sat = sum[ValW] ? DistOnes : sum[ValW-1:0];
          if (sat < bound_now) begin
            res.kind = KindMessage;
            res.dest = v;
            res.dist_res = sat;
          end
        end
        OpStepEnd: begin
          if (bound_next < bound_now) bound_now = bound_next;
          first_step = 1'b0;
          edges_on = 1'b0;
          msg_min = DistOnes;
        end
        default: ;
      endcase
      expected_relax.push_back(res);
    endfunction

    function void check_result(kind_t kind, logic [VtxW-1:0] dest, logic [ValW-1:0] dist_res,
                               logic upd);
      relax_res_t want;
      n_checked++;
      if (expected_relax.size() == 0) begin
        n_fail++;
        if (n_fail <= 10)
          $display("%0t: result with nothing expected: kind %0d dest %0d dist %h upd %0d",
                   $time, kind, dest, dist_res, upd);
        return;
      end
      want = expected_relax.pop_front();
      if (kind !== want.kind || dest !== want.dest || dist_res !== want.dist_res ||
          upd !== want.upd) begin
        n_fail++;
        if (n_fail <= 10)
          $display("%0t: mismatch: kind %0d/%0d dest %0d/%0d dist %h/%h upd %0d/%0d (exp/got)",
                   $time, want.kind, kind, want.dest, dest, want.dist_res, dist_res,
                   want.upd, upd);
      end
      if (want.kind == KindMessage) n_msg++;
      if (want.kind == KindTarget) n_target++;
      if (want.upd) n_upd++;
    endfunction

    function int report();
      if (expected_relax.size() != 0)
        $display("%0d expected results never arrived", expected_relax.size());
      return n_fail + expected_relax.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  bssp_in_if  in_if ();
  bssp_out_if out_if ();
  bssp_cfg_if cfg_if ();

  bounded_sssp_vertex_relaxation u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  relax_scoreboard sb;
  bit              idle_on;
  int              burst_left;
  int              items_sent;
  int              cfg_count;
  int unsigned     cycles;
  bit [VtxW-1:0]   vpool[$];

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("ERROR: run stopped at cycle limit with %0d results outstanding",
               sb.expected_relax.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      sb.check_result(kind_t'(out_if.kind), out_if.dest, out_if.dist_res, out_if.updated);
  end

  // Result side: changing stall patterns, plus one long hold-off that backs up the block.
  initial begin
    int          mode;
    int          left;
    int          step;
    logic [7:0]  mask;
    bit          held;
    out_if.ready <= 1'b0;
    mode = 0;
    left = 0;
    step = 0;
    mask = 8'hff;
    held = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (!held && sb.n_checked >= 300) begin
        held = 1'b1;
        out_if.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(32, 256);
          mask = 8'($urandom) | 8'h01;
        end
        left--;
        case (mode)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= ($urandom_range(0, 3) != 0);
          2: begin
            out_if.ready <= mask[step[2:0]];
            step++;
          end
          default: out_if.ready <= ($urandom_range(0, 2) == 0);
        endcase
      end
    end
  end

  function automatic logic [ValW-1:0] pick_dist();
    logic [ValW-1:0] b;
    b = sb.bound_now;
    case ($urandom_range(0, 9))
      0: return DistOnes;
      1: return '0;
      2: return $urandom_range(0, 1000);
      3, 4: return $urandom;
      5: return DistOnes - $urandom_range(0, 65535);
      // Values just under the bound make edge sums straddle it.
      default: return (b > 32'h20000) ? b - $urandom_range(1, 32'h20000) : $urandom_range(0, b);
    endcase
  endfunction

  function automatic logic [WgtW-1:0] pick_weight();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 16'($urandom_range(0, 31));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_item(input op_t op, input logic [VtxW-1:0] v,
                           input logic [ValW-1:0] value, input logic [WgtW-1:0] weight);
    int gap;
    if (idle_on && burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(1, 8);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    burst_left--;
    in_if.valid  <= 1'b1;
    in_if.op     <= op;
    in_if.vertex <= v;
    in_if.value  <= value;
    in_if.weight <= weight;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_item(op, v, value, weight);
    if (op <= OpStepEnd) items_sent++;
  endtask

  task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    sb.write_reg(idx, data);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.expected_relax.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_phase(input bit [VtxW-1:0] s, input bit [VtxW-1:0] t);
    drain();
    write_cfg(CfgSource, s);
    write_cfg(CfgTarget, t);
    cfg_count++;
  endtask

  initial begin
    bit [VtxW-1:0]   s, t, v;
    logic [ValW-1:0] base;
    op_t             op;
    int              n, r, fails;
    sb = new();
    rst_ni       <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.op     <= OpInit;
    in_if.vertex <= '0;
    in_if.value  <= '0;
    in_if.weight <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= CfgSource;
    cfg_if.data  <= '0;
    idle_on = 1'b0;
    burst_left = 0;
    items_sent = 0;
    cfg_count = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: source in the first superstep, saturation, bound edges, target hit.
    set_phase(16'h0000, 16'hFFFF);
    send_item(OpInit, 16'h0000, '0, '0);
    send_item(OpInit, 16'hFFFF, '0, '0);
    send_item(OpInit, 16'd100, '0, '0);
    send_item(OpEval, 16'h0000, '0, '0);
    send_item(OpEdge, 16'd100, '0, 16'h0000);
    send_item(OpEdge, 16'hFFFF, '0, 16'hFFFF);
    send_item(OpMessage, '0, 32'hFFFF_FFF0, '0);
    send_item(OpMessage, '0, DistOnes, '0);
    send_item(OpEval, 16'd100, '0, '0);
    send_item(OpEdge, 16'd200, '0, 16'hFFFF);
    send_item(OpEdge, 16'd200, '0, 16'd14);
    send_item(OpEdge, 16'd200, '0, 16'd15);
    send_item(OpMessage, '0, 32'hFFFF_0000, '0);
    send_item(OpEval, 16'hFFFF, '0, '0);
    send_item(OpEdge, 16'd300, '0, 16'd1);
    send_item(op_t'(5), '1, DistOnes, '1);
    send_item(op_t'(6), '1, DistOnes, '1);
    send_item(op_t'(7), '1, DistOnes, '1);
    send_item(OpStepEnd, '0, '0, '0);
    send_item(OpMessage, '0, 32'hFFFE_FFF0, '0);
    send_item(OpEval, 16'd100, '0, '0);
    send_item(OpEdge, 16'd400, '0, 16'h000F);
    send_item(OpEdge, 16'd400, '0, 16'h0010);
    send_item(OpEval, 16'h0000, '0, '0);
    send_item(OpInit, 16'hFFFF, DistOnes, '1);

    // Random part: vertex jobs of messages, evaluate and edges, with noise mixed in.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin
          s = 16'($urandom);
          t = 16'($urandom);
        end
        1: begin
          s = 16'hFFFF;
          t = 16'h0000;
        end
        2: begin
          s = 16'h0000;
          t = 16'hFFFF;
        end
        default: begin
          s = 16'($urandom);
          t = s;
        end
      endcase
      set_phase(s, t);
      idle_on = (ph != 2);
      vpool.delete();
      for (int k = 0; k < 9; k++) begin
        v = (k == 0) ? s : (k == 1) ? 16'h0000 : (k == 2) ? 16'hFFFF : 16'($urandom);
        if (v != t) begin
          send_item(OpInit, v, $urandom, 16'($urandom));
          vpool.push_back(v);
        end
      end
      while (items_sent < 25 + (ph + 1) * 166) begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          v = vpool[$urandom_range(0, vpool.size() - 1)];
          n = $urandom_range(0, 4);
          repeat (n) send_item(OpMessage, 16'($urandom), pick_dist(), 16'($urandom));
          send_item(OpEval, v, $urandom, 16'($urandom));
          n = $urandom_range(0, 5);
          repeat (n) send_item(OpEdge, 16'($urandom), $urandom, pick_weight());
        end else if (r < 62) begin
          // Target hits lower the bound only a little, so later edges still get through.
          base = (sb.bound_next < sb.bound_now) ? sb.bound_next : sb.bound_now;
          if (!sb.dist_tab.exists(t)) send_item(OpInit, t, $urandom, 16'($urandom));
          if (base > 32'd70000)
            send_item(OpMessage, 16'($urandom), base - $urandom_range(1, 65536),
                      16'($urandom));
          send_item(OpEval, t, $urandom, 16'($urandom));
          send_item(OpEdge, 16'($urandom), $urandom, pick_weight());
        end else if (r < 72) begin
          v = ($urandom_range(0, 3) == 0) ? vpool[$urandom_range(0, vpool.size() - 1)]
                                          : 16'($urandom);
          send_item(OpInit, v, $urandom, 16'($urandom));
          if (v != t && vpool.size() < 40) vpool.push_back(v);
        end else if (r < 80) begin
          send_item(OpStepEnd, 16'($urandom), $urandom, 16'($urandom));
        end else begin
          op = op_t'($urandom_range(0, 7));
          v = (op == OpEval) ? vpool[$urandom_range(0, vpool.size() - 1)] : 16'($urandom);
          send_item(op, v, (op == OpMessage) ? pick_dist() : 32'($urandom), 16'($urandom));
        end
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    fails = sb.report();
    $display("Covered %0d items and %0d results across %0d source/target settings.",
             items_sent, sb.n_checked, cfg_count);
    $display("Seen: %0d neighbor messages, %0d target hits, %0d distance updates.",
             sb.n_msg, sb.n_target, sb.n_upd);
    if (fails == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
